// ===== hw/rtl/ils_pkg.sv =====
// shared constants, types and helpers for the integer lifo stack
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_PEEK  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef logic [DATA_WIDTH-1:0] entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ils_shift_t;

    function automatic entry_t to_entry(input logic [WORD_W-1:0] v);
        logic [63:0] ext;
        begin
            ext = {{(64 - WORD_W){v[WORD_W-1]}}, v};
            return ext[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic logic [WORD_W-1:0] from_entry(input entry_t e);
        logic [63:0] ext;
        begin
            ext = 64'(e);
            return ext[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ils_cell.sv =====
// one stack cell: holds an entry and takes its neighbor's entry on push or pop
`timescale 1ns / 1ps
`default_nettype none

module ils_cell
    import ils_pkg::*;
(
    input  wire logic       clk,
    input  wire ils_shift_t shift,
    input  wire entry_t     above,
    input  wire entry_t     below,
    output entry_t          entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        priority if (shift.push)
        begin
            entry_next = above;
        end
        else if (shift.pop)
        begin
            entry_next = below;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_chain.sv =====
// row of stack cells, top of stack in cell zero
`timescale 1ns / 1ps
`default_nettype none

module ils_chain
    import ils_pkg::*;
(
    input  wire logic       clk,
    input  wire ils_shift_t shift,
    input  wire entry_t     push_entry,
    output entry_t          top
);

    entry_t entries [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            entry_t above_w;
            entry_t below_w;

            if (i == 0)
            begin : g_first
                assign above_w = push_entry;
            end
            else
            begin : g_mid
                assign above_w = entries[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign below_w = '0;
            end
            else
            begin : g_inner
                assign below_w = entries[i+1];
            end

            ils_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .above (above_w),
                .below (below_w),
                .entry (entries[i])
            );
        end
    endgenerate

    assign top = entries[0];

endmodule

`default_nettype wire

// ===== hw/rtl/integer_lifo_stack.sv =====
// bounded lifo stack of signed words built from a shifting row of cells
// the result of an accepted word is held in the output register from the next cycle
// throughput: one word per cycle while req_stall is low, every action shifts the cell row at most once
// the output register frees up in the cycle its result is taken
// reset clears the occupancy register and the output valid; cell contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module integer_lifo_stack
    import ils_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  wire logic [1:0]               action,
    input  wire logic signed [WORD_W-1:0] value,
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output logic signed [WORD_W-1:0]      data,
    output logic [1:0]                    status,
    output logic [CNT_W-1:0]              count,
    output logic                          empty_res,
    output logic                          full_res
);

    logic             occ_is_empty;
    logic             occ_is_full;
    logic             req_accept;
    ils_shift_t       shift;
    entry_t           top;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [CNT_W-1:0] count_reg;
    logic             empty_reg;
    logic             full_reg;

    assign occ_is_empty = (occ_reg == '0);
    assign occ_is_full  = (occ_reg == CNT_W'(DEPTH));
    assign req_stall    = rsp_valid_reg && rsp_stall;
    assign req_accept   = req_valid && !req_stall;

    always_comb
    begin
        shift       = '0;
        occ_next    = occ_reg;
        data_next   = '0;
        status_next = ST_OK;
        unique case (action)
            ACT_PUSH:
            begin
                if (occ_is_full)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    shift.push = req_accept;
                    occ_next   = occ_reg + CNT_W'(1);
                end
            end
            ACT_POP:
            begin
                if (occ_is_empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    shift.pop = req_accept;
                    occ_next  = occ_reg - CNT_W'(1);
                    data_next = from_entry(top);
                end
            end
            ACT_PEEK:
            begin
                if (occ_is_empty)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    data_next = from_entry(top);
                end
            end
            ACT_CLEAR:
            begin
                occ_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    ils_chain u_chain (
        .clk        (clk),
        .shift      (shift),
        .push_entry (to_entry(value)),
        .top        (top)
    );

    always_comb
    begin
        priority if (req_accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_accept)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            data_reg   <= data_next;
            status_reg <= status_next;
            count_reg  <= occ_next;
            empty_reg  <= (occ_next == '0);
            full_reg   <= (occ_next == CNT_W'(DEPTH));
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign empty_res = empty_reg;
    assign full_res  = full_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && action == ACT_PUSH && !occ_is_full
        |=> occ_reg == $past(occ_reg) + CNT_W'(1))
        else $error("push did not grow the stack");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_UNDERFLOW || status == ST_OVERFLOW) |-> data == '0)
        else $error("error result carries data");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (empty_res == (count == '0)) && !(empty_res && full_res))
        else $error("flags disagree with count");

endmodule

`default_nettype wire
